// ----- sv/lbpc_pkg.sv -----
package lbpc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MS_W     = 16;
    localparam int TIME_W   = 17;
    localparam int CODE_W   = 3;
    localparam int BTN_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int BUTTON_COUNT_DEF = 4;
    localparam int TICK_MS          = 20;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [SAMPLE_W-1:0] NO_PRESS_ABOVE_MV = SAMPLE_W'(3000);
    localparam logic [TIME_W-1:0]   TIME_MAX          = {TIME_W{1'b1}};

    typedef logic [CODE_W-1:0] t_code;
    localparam t_code HELD_NONE = CODE_W'(4);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2
    } t_phase;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LONG    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TOL     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET0 = CFG_IDX_W'(3);

    localparam logic [MS_W-1:0]     SHORT_RST  = MS_W'(40);
    localparam logic [MS_W-1:0]     LONG_RST   = MS_W'(1000);
    localparam logic [SAMPLE_W-1:0] TOL_RST    = SAMPLE_W'(100);

    function automatic logic [SAMPLE_W-1:0] target_rst(input int idx);
        logic [SAMPLE_W-1:0] v;
        v = SAMPLE_W'(700 * idx);
        return v;
    endfunction

    typedef struct packed {
        logic [MS_W-1:0] short_ms;
        logic [MS_W-1:0] long_ms;
    } t_press_cfg;

endpackage

// ----- sv/lbpc_classify.sv -----
module lbpc_classify #(
    parameter int BUTTON_COUNT = lbpc_pkg::BUTTON_COUNT_DEF
) (
    input  logic [lbpc_pkg::SAMPLE_W-1:0]                   i_sample_mv,
    input  logic [lbpc_pkg::SAMPLE_W-1:0]                   i_tolerance_mv,
    input  logic [BUTTON_COUNT-1:0][lbpc_pkg::SAMPLE_W-1:0] i_targets,
    output lbpc_pkg::t_code                                 o_code
);

    logic [lbpc_pkg::SAMPLE_W:0] w_up;
    logic [lbpc_pkg::SAMPLE_W:0] w_hi [BUTTON_COUNT];

    assign w_up = {1'b0, i_sample_mv} + {1'b0, i_tolerance_mv};

    // Window test without signed math: target-tol <= s  <=>  s+tol >= target.
    always_comb begin
        o_code = lbpc_pkg::HELD_NONE;
        for (int b = BUTTON_COUNT - 1; b >= 0; b--) begin
            w_hi[b] = {1'b0, i_targets[b]} + {1'b0, i_tolerance_mv};
            if (w_up >= {1'b0, i_targets[b]} && {1'b0, i_sample_mv} <= w_hi[b]) begin
                o_code = lbpc_pkg::CODE_W'(b);
            end
        end
        if (i_sample_mv > lbpc_pkg::NO_PRESS_ABOVE_MV) begin
            o_code = lbpc_pkg::HELD_NONE;
        end
    end

endmodule

// ----- sv/lbpc_queue.sv -----
module lbpc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbpc_pkg::t_code i_data,
    output logic            o_not_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lbpc_pkg::t_code o_data
);

    localparam int DEPTH = lbpc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbpc_pkg::t_code  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_not_full = (r_count != CNT_W'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_data     = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

// ----- sv/lbpc_press.sv -----
module lbpc_press (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lbpc_pkg::t_press_cfg i_cfg,
    input  logic                 i_q_valid,
    input  lbpc_pkg::t_code      i_q_code,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [lbpc_pkg::BTN_W-1:0] o_button,
    output logic                 o_press_kind
);

    lbpc_pkg::t_phase                r_phase, n_phase;
    lbpc_pkg::t_code                 r_held, n_held;
    logic [lbpc_pkg::TIME_W-1:0]     r_time, n_time;
    logic                            r_out_valid, n_out_valid;
    logic [lbpc_pkg::BTN_W-1:0]      r_out_button, n_out_button;
    logic                            r_out_kind, n_out_kind;
    logic [lbpc_pkg::TIME_W:0]       w_sum;
    logic [lbpc_pkg::TIME_W-1:0]     w_time_inc;
    logic                            w_pop;

    assign w_pop      = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop    = w_pop;
    assign o_valid    = r_out_valid;
    assign o_button   = r_out_button;
    assign o_press_kind = r_out_kind;

    assign w_sum      = {1'b0, r_time} + (lbpc_pkg::TIME_W + 1)'(lbpc_pkg::TICK_MS);
    assign w_time_inc = w_sum[lbpc_pkg::TIME_W] ? lbpc_pkg::TIME_MAX
                                                : w_sum[lbpc_pkg::TIME_W-1:0];

    always_comb begin
        n_phase      = r_phase;
        n_held       = r_held;
        n_time       = r_time;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_button = r_out_button;
        n_out_kind   = r_out_kind;
        if (w_pop) begin
            case (r_phase)
                lbpc_pkg::PH_PRESSED: begin
                    if (i_q_code == r_held) begin
                        n_time = w_time_inc;
                        if (w_time_inc >= {1'b0, i_cfg.long_ms}) begin
                            n_phase      = lbpc_pkg::PH_LONG;
                            n_out_valid  = 1'b1;
                            n_out_button = r_held[lbpc_pkg::BTN_W-1:0];
                            n_out_kind   = lbpc_pkg::KIND_LONG;
                        end
                    end else begin
                        if (r_time >= {1'b0, i_cfg.short_ms}) begin
                            n_out_valid  = 1'b1;
                            n_out_button = r_held[lbpc_pkg::BTN_W-1:0];
                            n_out_kind   = lbpc_pkg::KIND_SHORT;
                        end
                        n_phase = lbpc_pkg::PH_IDLE;
                        n_held  = lbpc_pkg::HELD_NONE;
                    end
                end
                lbpc_pkg::PH_LONG: begin
                    if (i_q_code != r_held) begin
                        n_phase = lbpc_pkg::PH_IDLE;
                        n_held  = lbpc_pkg::HELD_NONE;
                    end
                end
                default: begin
                    if (i_q_code != lbpc_pkg::HELD_NONE) begin
                        n_held  = i_q_code;
                        n_time  = '0;
                        n_phase = lbpc_pkg::PH_PRESSED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lbpc_pkg::PH_IDLE;
            r_held      <= lbpc_pkg::HELD_NONE;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_button <= n_out_button;
        r_out_kind   <= n_out_kind;
    end

    a_held_when_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != lbpc_pkg::PH_IDLE |-> r_held != lbpc_pkg::HELD_NONE)
        else $error("active phase without a held button");

    a_none_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == lbpc_pkg::PH_IDLE |-> r_held == lbpc_pkg::HELD_NONE)
        else $error("idle phase still holds a button");

    a_long_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase == lbpc_pkg::PH_LONG) |->
            r_out_valid && r_out_kind == lbpc_pkg::KIND_LONG)
        else $error("long phase entered without a long-press event");

endmodule

// ----- sv/ladder_button_press_classifier.sv -----
// Channel  Direction  Handshake           Payload
// sample   in         i_valid / o_ready   i_sample_mv[11:0]
// event    out        o_valid / i_ready   o_button[1:0], o_press_kind
// config   in         i_cfg_we            i_cfg_idx[2:0], i_cfg_data[15:0]
//
// One sample per cycle sustained while o_ready is high. A sample is classified as
// it is accepted and queued; the press tracker takes it from the queue, and its
// event is registered into the output register that drives o_valid.
// Reset (synchronous) loads the default thresholds and targets, empties the
// queue and returns the tracker to idle.
// The two-entry queue absorbs back pressure; the tracker holds while an event
// waits in its output register, and o_ready drops only when the queue is full.
module ladder_button_press_classifier #(
    parameter int BUTTON_COUNT = lbpc_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lbpc_pkg::SAMPLE_W-1:0]       i_sample_mv,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lbpc_pkg::BTN_W-1:0]          o_button,
    output logic                                o_press_kind,
    input  logic                                i_cfg_we,
    input  logic [lbpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lbpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lbpc_pkg::t_press_cfg                    r_press_cfg;
    logic [lbpc_pkg::SAMPLE_W-1:0]           r_tolerance;
    logic [BUTTON_COUNT-1:0][lbpc_pkg::SAMPLE_W-1:0] r_targets;

    lbpc_pkg::t_code w_code;
    lbpc_pkg::t_code w_q_code;
    logic            w_not_full;
    logic            w_q_valid;
    logic            w_q_pop;
    logic            w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_cfg.short_ms <= lbpc_pkg::SHORT_RST;
            r_press_cfg.long_ms  <= lbpc_pkg::LONG_RST;
            r_tolerance          <= lbpc_pkg::TOL_RST;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_targets[b] <= lbpc_pkg::target_rst(b);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lbpc_pkg::CFG_SHORT: r_press_cfg.short_ms <= i_cfg_data;
                lbpc_pkg::CFG_LONG:  r_press_cfg.long_ms  <= i_cfg_data;
                lbpc_pkg::CFG_TOL:   r_tolerance <= i_cfg_data[lbpc_pkg::SAMPLE_W-1:0];
                default: begin
                    for (int b = 0; b < BUTTON_COUNT; b++) begin
                        if (i_cfg_idx == lbpc_pkg::CFG_IDX_W'(32'(lbpc_pkg::CFG_TARGET0) + b)) begin
                            r_targets[b] <= i_cfg_data[lbpc_pkg::SAMPLE_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    lbpc_classify #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_classify (
        .i_sample_mv    (i_sample_mv),
        .i_tolerance_mv (r_tolerance),
        .i_targets      (r_targets),
        .o_code         (w_code)
    );

    assign o_ready = w_not_full;
    assign w_push  = i_valid && w_not_full;

    lbpc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_code),
        .o_not_full (w_not_full),
        .i_pop      (w_q_pop),
        .o_valid    (w_q_valid),
        .o_data     (w_q_code)
    );

    lbpc_press u_press (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_press_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_code     (w_q_code),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_button     (o_button),
        .o_press_kind (o_press_kind)
    );

endmodule

// ----- tb/sv/ladder_button_press_classifier_tb.sv -----
`timescale 1ns / 1ps

module ladder_button_press_classifier_tb;

    localparam logic [lbpc_pkg::CFG_IDX_W-1:0] CFG_TARGET1 =
        lbpc_pkg::CFG_TARGET0 + lbpc_pkg::CFG_IDX_W'(1);
    localparam logic [lbpc_pkg::CFG_IDX_W-1:0] CFG_TARGET2 =
        lbpc_pkg::CFG_TARGET0 + lbpc_pkg::CFG_IDX_W'(2);
    localparam logic [lbpc_pkg::CFG_IDX_W-1:0] CFG_TARGET3 =
        lbpc_pkg::CFG_TARGET0 + lbpc_pkg::CFG_IDX_W'(3);
    localparam logic [lbpc_pkg::CFG_IDX_W-1:0] CFG_SPARE   = lbpc_pkg::CFG_IDX_W'(7);
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN  = 80;
    localparam int PHASE_SAMPLES = 240;

    typedef struct packed {
        logic [lbpc_pkg::BTN_W-1:0] button;
        logic                       kind;
    } t_press_event;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [lbpc_pkg::SAMPLE_W-1:0]   i_sample_mv = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [lbpc_pkg::BTN_W-1:0]      o_button;
    logic                            o_press_kind;
    logic                            i_cfg_we = 1'b0;
    logic [lbpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [lbpc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the register file
    logic [lbpc_pkg::MS_W-1:0]     cfg_short_ms = 16'd40;
    logic [lbpc_pkg::MS_W-1:0]     cfg_long_ms = 16'd1000;
    logic [lbpc_pkg::SAMPLE_W-1:0] cfg_tol_mv = 12'd100;
    logic [lbpc_pkg::SAMPLE_W-1:0] cfg_target_mv [4] = '{12'd0, 12'd700, 12'd1400, 12'd2100};

    // press tracker state
    lbpc_pkg::t_phase            trk_phase = lbpc_pkg::PH_IDLE;
    lbpc_pkg::t_code             trk_held = lbpc_pkg::HELD_NONE;
    logic [lbpc_pkg::TIME_W-1:0] trk_time = '0;

    t_press_event expected_events[$];
    int           mismatches = 0;
    int           samples_sent = 0;
    int           quiet_cycles = 0;
    int           hold_left = 0;
    bit           hold_req = 1'b0;
    bit           steady_flow = 1'b0;

    ladder_button_press_classifier dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample_mv  (i_sample_mv),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_button     (o_button),
        .o_press_kind (o_press_kind),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lowest button whose window holds the sample wins
    function automatic lbpc_pkg::t_code classify_mv(input logic [lbpc_pkg::SAMPLE_W-1:0] mv);
        int smp;
        int lo;
        int hi;
        smp = int'(mv);
        if (mv > lbpc_pkg::NO_PRESS_ABOVE_MV) return lbpc_pkg::HELD_NONE;
        for (int i = 0; i < lbpc_pkg::BUTTON_COUNT_DEF; i++) begin
            lo = int'(cfg_target_mv[i]) - int'(cfg_tol_mv);
            hi = int'(cfg_target_mv[i]) + int'(cfg_tol_mv);
            if (smp >= lo && smp <= hi) return lbpc_pkg::t_code'(i);
        end
        return lbpc_pkg::HELD_NONE;
    endfunction

    task automatic track_sample(input logic [lbpc_pkg::SAMPLE_W-1:0] mv);
        lbpc_pkg::t_code           now_btn;
        logic [lbpc_pkg::TIME_W:0] grown;
        now_btn = classify_mv(mv);
        case (trk_phase)
            lbpc_pkg::PH_PRESSED: begin
                if (now_btn == trk_held) begin
                    grown = {1'b0, trk_time} + (lbpc_pkg::TIME_W + 1)'(lbpc_pkg::TICK_MS);
                    trk_time = (grown > lbpc_pkg::TIME_MAX) ? lbpc_pkg::TIME_MAX
                                                            : grown[lbpc_pkg::TIME_W-1:0];
                    if (trk_time >= cfg_long_ms) begin
                        trk_phase = lbpc_pkg::PH_LONG;
                        expected_events.push_back('{trk_held[lbpc_pkg::BTN_W-1:0],
                                                    lbpc_pkg::KIND_LONG});
                    end
                end else begin
                    if (trk_time >= cfg_short_ms)
                        expected_events.push_back('{trk_held[lbpc_pkg::BTN_W-1:0],
                                                    lbpc_pkg::KIND_SHORT});
                    trk_phase = lbpc_pkg::PH_IDLE;
                    trk_held = lbpc_pkg::HELD_NONE;
                end
            end
            lbpc_pkg::PH_LONG: begin
                if (now_btn != trk_held) begin
                    trk_phase = lbpc_pkg::PH_IDLE;
                    trk_held = lbpc_pkg::HELD_NONE;
                end
            end
            default: begin
                if (now_btn != lbpc_pkg::HELD_NONE) begin
                    trk_held = now_btn;
                    trk_time = '0;
                    trk_phase = lbpc_pkg::PH_PRESSED;
                end
            end
        endcase
    endtask

    function automatic logic [lbpc_pkg::SAMPLE_W-1:0] window_sample(input int btn);
        int lo;
        int hi;
        lo = int'(cfg_target_mv[btn]) - int'(cfg_tol_mv);
        hi = int'(cfg_target_mv[btn]) + int'(cfg_tol_mv);
        if (lo < 0) lo = 0;
        if (hi > int'(lbpc_pkg::NO_PRESS_ABOVE_MV)) hi = int'(lbpc_pkg::NO_PRESS_ABOVE_MV);
        if (lo > hi) return cfg_target_mv[btn];
        return lbpc_pkg::SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    task automatic send_sample(input logic [lbpc_pkg::SAMPLE_W-1:0] mv);
        while (!steady_flow && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_mv <= mv;
        do @(posedge i_clk); while (!o_ready);
        track_sample(mv);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lbpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbpc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lbpc_pkg::CFG_SHORT:   cfg_short_ms = data;
            lbpc_pkg::CFG_LONG:    cfg_long_ms = data;
            lbpc_pkg::CFG_TOL:     cfg_tol_mv = data[lbpc_pkg::SAMPLE_W-1:0];
            lbpc_pkg::CFG_TARGET0: cfg_target_mv[0] = data[lbpc_pkg::SAMPLE_W-1:0];
            CFG_TARGET1:           cfg_target_mv[1] = data[lbpc_pkg::SAMPLE_W-1:0];
            CFG_TARGET2:           cfg_target_mv[2] = data[lbpc_pkg::SAMPLE_W-1:0];
            CFG_TARGET3:           cfg_target_mv[3] = data[lbpc_pkg::SAMPLE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [lbpc_pkg::CFG_DATA_W-1:0] short_ms, long_ms, tol,
                                input logic [lbpc_pkg::CFG_DATA_W-1:0] t0, t1, t2, t3);
        write_reg(lbpc_pkg::CFG_SHORT, short_ms);
        write_reg(lbpc_pkg::CFG_LONG, long_ms);
        write_reg(lbpc_pkg::CFG_TOL, tol);
        write_reg(lbpc_pkg::CFG_TARGET0, t0);
        write_reg(CFG_TARGET1, t1);
        write_reg(CFG_TARGET2, t2);
        write_reg(CFG_TARGET3, t3);
        // a write past the register list must change nothing
        write_reg(CFG_SPARE, 16'($urandom()));
    endtask

    // hold the sender until every event is out and the queue has emptied
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic test_default_press();
        // short press on button one at exactly the short threshold
        repeat (3) send_sample(12'd700);
        send_sample(12'd3500);
        // release before the short threshold: no event
        send_sample(12'd0);
        send_sample(12'd4095);
        // upper window edge latches, one past it releases
        send_sample(12'd2200);
        send_sample(12'd2201);
        settle();
    endtask

    task automatic test_threshold_extremes();
        apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd3000, 16'd4095);
        // zero long threshold fires on the first tick after the latch
        send_sample(12'd3000);
        send_sample(12'd3000);
        send_sample(12'd3001);
        // change of button with zero short threshold
        send_sample(12'd0);
        send_sample(12'd1000);
        send_sample(12'd4095);
        send_sample(12'd999);
        settle();
    endtask

    task automatic test_overlap();
        // every window covers the whole range: button zero wins every sample up to 3000 mV
        apply_config(16'd20, 16'd40, 16'hFFFF, 16'd2000, 16'd1000, 16'd500, 16'd0);
        send_sample(12'd1000);
        send_sample(12'd2999);
        send_sample(12'd0);
        send_sample(12'd3001);
        settle();
    endtask

    task automatic test_backpressure();
        // every other sample makes an event, so a stalled receiver fills the block
        apply_config(16'd0, 16'hFFFF, 16'd100, 16'd0, 16'd700, 16'd1400, 16'd2100);
        steady_flow = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_sample(i[0] ? 12'd700 : 12'd0);
        settle();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_phases();
        int stop_at;
        int ticks;
        int max_ticks;
        int btn;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_config(16'd0, 16'd0, 16'd0, 16'($urandom_range(0, 3000)),
                                16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                                16'($urandom_range(0, 3000)));
                1: apply_config(16'hFFFF, 16'hFFFF, 16'd4095, 16'd4095, 16'd0,
                                16'hFFFF, 16'd2048);
                2: apply_config(16'd40, 16'd200, 16'd100, 16'd0, 16'd700, 16'd1400, 16'd2100);
                default: apply_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 800)),
                                      {4'($urandom()), 12'($urandom_range(0, 500))},
                                      {4'($urandom()), 12'($urandom_range(0, 3000))},
                                      {4'($urandom()), 12'($urandom_range(0, 3000))},
                                      {4'($urandom()), 12'($urandom_range(0, 3000))},
                                      {4'($urandom()), 12'($urandom())});
            endcase
            steady_flow = (ph == 2);
            max_ticks = (cfg_long_ms / lbpc_pkg::TICK_MS > 56) ? 60
                                                               : cfg_long_ms / lbpc_pkg::TICK_MS + 4;
            stop_at = samples_sent + PHASE_SAMPLES;
            while (samples_sent < stop_at) begin
                if ($urandom_range(0, 99) < 20) begin
                    send_sample(lbpc_pkg::SAMPLE_W'($urandom_range(0, 4095)));
                end else begin
                    btn = $urandom_range(0, lbpc_pkg::BUTTON_COUNT_DEF - 1);
                    ticks = $urandom_range(1, max_ticks);
                    repeat (ticks) send_sample(window_sample(btn));
                    if ($urandom_range(0, 99) < 60)
                        send_sample(lbpc_pkg::SAMPLE_W'($urandom_range(3001, 4095)));
                end
            end
            settle();
        end
        steady_flow = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF_LEN;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady_flow || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge i_clk) begin : event_check
        t_press_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_events.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected event, expected none, got button %0d kind %0d",
                         $time, o_button, o_press_kind);
            end else begin
                want = expected_events.pop_front();
                if (o_button !== want.button) begin
                    mismatches++;
                    $display("%0t: button expected %0d got %0d", $time, want.button, o_button);
                end
                if (o_press_kind !== want.kind) begin
                    mismatches++;
                    $display("%0t: press kind expected %0d got %0d",
                             $time, want.kind, o_press_kind);
                end
            end
        end
    end

    // end the run when no request moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_press();
        test_threshold_extremes();
        test_overlap();
        test_backpressure();
        test_random_phases();
        settle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lbpc_pkg.sv
sv/lbpc_classify.sv
sv/lbpc_queue.sv
sv/lbpc_press.sv
sv/ladder_button_press_classifier.sv
tb/sv/ladder_button_press_classifier_tb.sv
